// ===== hw/rtl/emg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emg_pkg: shared types and constants of the EMG envelope chain
// Fixed widths of the data path, register indexes, sequencer states and
// the request/response structs of the shared divider.
// ----------------------------------------------------------------------------
package emg_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 16;
  localparam int unsigned HP_W     = 26;
  localparam int unsigned LP_W     = 25;
  localparam int unsigned ENV_W    = 24;
  localparam int unsigned VAR_W    = 32;
  localparam int unsigned MVC_W    = 24;
  localparam int unsigned LEVEL_W  = 17;
  localparam int unsigned DZ_W     = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned MUL_A_W  = 32;
  localparam int unsigned MUL_B_W  = 17;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;

  localparam int unsigned DIV_N_W  = 32;
  localparam int unsigned DIV_D_W  = 33;
  localparam int unsigned QUOT_W   = 17;

  localparam logic [COEF_W-1:0]  COEF_ONE  = 16'd32768;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HP_COEF  = 3'd0,
    CFG_LP_COEF  = 3'd1,
    CFG_PNS      = 3'd2,
    CFG_MEAS     = 3'd3,
    CFG_MVC      = 3'd4,
    CFG_DEADZONE = 3'd5,
    CFG_ON       = 3'd6,
    CFG_OFF      = 3'd7
  } cfg_idx_e;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_HP    = 15'b000000000000010,
    S_HPR   = 15'b000000000000100,
    S_LP    = 15'b000000000001000,
    S_LPR   = 15'b000000000010000,
    S_KDIV  = 15'b000000000100000,
    S_KFM   = 15'b000000001000000,
    S_KF    = 15'b000000010000000,
    S_KFR   = 15'b000000100000000,
    S_VAR   = 15'b000001000000000,
    S_VARR  = 15'b000010000000000,
    S_NDIV  = 15'b000100000000000,
    S_NPOST = 15'b001000000000000,
    S_PDIV  = 15'b010000000000000,
    S_FIN   = 15'b100000000000000
  } state_e;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] num;
    logic [DIV_D_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

// ===== hw/rtl/emg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emg_in_if / emg_out_if: valid/ready channels of the envelope chain
// Input carries one raw sample, output one result item.
// ----------------------------------------------------------------------------
interface emg_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] raw_sample;
  modport source (output valid, output raw_sample, input ready);
  modport sink   (input valid, input raw_sample, output ready);
endinterface

interface emg_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] envelope;
  logic [16:0] normalized;
  logic [16:0] proportional;
  logic        contracted;
  modport source (output valid, output envelope, output normalized,
                  output proportional, output contracted, input ready);
  modport sink   (input valid, input envelope, input normalized,
                  input proportional, input contracted, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/emg_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emg_div: restoring divider, one quotient bit per cycle
// Computes (num << 16) / den for quotients below 2^17.
// ----------------------------------------------------------------------------
module emg_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire emg_pkg::div_req_t req_i,
  output      emg_pkg::div_rsp_t rsp_o
);
  import emg_pkg::*;

  localparam logic [4:0] LAST_STEP = 5'(QUOT_W - 1);

  logic [DIV_D_W-1:0] rem_q, rem_d;
  logic [DIV_D_W-1:0] den_q;
  logic [QUOT_W-1:0]  bring_q;
  logic [QUOT_W-1:0]  quot_q;
  logic [4:0]         cnt_q;
  logic               busy_q, done_q;
  logic [DIV_D_W:0]   trial;
  logic               ge;

  always_comb begin
    trial = {rem_q, bring_q[QUOT_W-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? DIV_D_W'(trial - {1'b0, den_q}) : trial[DIV_D_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Start with the remainder below the divisor; bring in num[0], then zeros.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q   <= {2'b0, req_i.num[DIV_N_W-1:1]};
      bring_q <= {req_i.num[0], 16'b0};
      den_q   <= req_i.den;
    end else if (busy_q) begin
      rem_q   <= rem_d;
      bring_q <= {bring_q[QUOT_W-2:0], 1'b0};
      quot_q  <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule
`default_nettype wire

// ===== hw/rtl/emg_envelope_chain.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// emg_envelope_chain: EMG high-pass, rectify, envelope, Kalman, hysteresis
// Each result item runs through up to three divisions (Kalman gain,
// normalization, proportional rescale), each one waiting on the shared
// divider, and four passes through the shared registered multiplier, plus
// the sequencer steps. A division is skipped on zero total variance, an
// envelope at twice MVC or more, or a level inside the deadzone. The block
// takes no new item until the current one is handed to the output register,
// and it stalls in its last step while an earlier result item waits there.
// Reset is asynchronous: configuration registers return to their defaults,
// the filter state clears, and the variance returns to one.
// ----------------------------------------------------------------------------
module emg_envelope_chain (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  emg_in_if.sink                         in_ch,
  emg_out_if.source                      out_ch,
  input  wire logic                      cfg_we_i,
  input  wire logic [emg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [emg_pkg::CFG_W-1:0] cfg_data_i
);
  import emg_pkg::*;

  localparam logic [LP_W-1:0]  LP_MAX  = '1;
  localparam logic [ENV_W-1:0] ENV_MAX = '1;

  // configuration registers
  logic [COEF_W-1:0]  hp_coef_q, lp_coef_q;
  logic [VAR_W-1:0]   pns_q, meas_q;
  logic [MVC_W-1:0]   mvc_q;
  logic [DZ_W-1:0]    dz_q;
  logic [LEVEL_W-1:0] on_q, off_q;

  // filter state
  logic [SAMPLE_W-1:0] hp_last_in_q;
  logic [HP_W-1:0]     hp_last_out_q;
  logic [LP_W-1:0]     lp_env_q;
  logic [ENV_W-1:0]    kf_env_q;
  logic [VAR_W-1:0]    kf_var_q;
  logic                flag_q, primed_q;

  // sequencer and work registers
  state_e              state_q;
  logic [MUL_A_W-1:0]  mul_a_q;
  logic [MUL_B_W-1:0]  mul_b_q;
  logic [PROD_W-1:0]   prod_q;
  logic                neg_q;
  logic [VAR_W-1:0]    p_q;
  logic [QUOT_W-1:0]   k_q;
  logic [LEVEL_W-1:0]  norm_q, prop_q;

  // output register
  logic                out_valid_q;
  logic [ENV_W-1:0]    out_env_q;
  logic [LEVEL_W-1:0]  out_norm_q, out_prop_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  emg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---- combinational helpers ----------------------------------------------
  logic [COEF_W-1:0]   hpc_lim, lpc_lim;
  logic [SAMPLE_W-1:0] li_eff;
  logic [HP_W-1:0]     lo_eff;
  logic [16:0]         x_diff;
  logic [26:0]         hp_sum, hp_mag;
  logic [PROD_W-1:0]   rnd15, rnd16;
  logic [27:0]         hp_m;
  logic [HP_W-1:0]     hp_sat;
  logic [LP_W-1:0]     rect;
  logic [LP_W:0]       lp_diff;
  logic [LP_W-1:0]     lp_dmag;
  logic [25:0]         lp_m;
  logic [26:0]         lp_t;
  logic [LP_W-1:0]     lp_new;
  logic [VAR_W:0]      p_sum;
  logic [VAR_W-1:0]    p_new;
  logic [DIV_D_W-1:0]  den;
  logic [LP_W:0]       kf_diff;
  logic [LP_W-1:0]     kf_dmag;
  logic [25:0]         kf_m;
  logic [27:0]         kf_t;
  logic [ENV_W-1:0]    env_new;
  logic [MVC_W-1:0]    mvc_eff;
  logic                flag_n;

  always_comb begin
    hpc_lim = (hp_coef_q > COEF_ONE) ? COEF_ONE : hp_coef_q;
    lpc_lim = (lp_coef_q > COEF_ONE) ? COEF_ONE : lp_coef_q;

    // priming: the first sample takes itself as the previous input
    li_eff  = primed_q ? hp_last_in_q : in_ch.raw_sample;
    lo_eff  = primed_q ? hp_last_out_q : '0;
    x_diff  = {in_ch.raw_sample[SAMPLE_W-1], in_ch.raw_sample}
            - {li_eff[SAMPLE_W-1], li_eff};
    hp_sum  = {lo_eff[HP_W-1], lo_eff} + {{2{x_diff[16]}}, x_diff, 8'b0};
    hp_mag  = hp_sum[26] ? 27'(-hp_sum) : hp_sum;

    // round halves away from zero on the magnitude
    rnd15   = prod_q + PROD_W'(16384);
    rnd16   = prod_q + PROD_W'(32768);

    hp_m    = rnd15[42:15];
    if (!neg_q) begin
      hp_sat = (hp_m > 28'h1FFFFFF) ? 26'h1FFFFFF : hp_m[HP_W-1:0];
    end else begin
      hp_sat = (hp_m > 28'h2000000) ? 26'h2000000 : 26'(-hp_m[HP_W-1:0]);
    end
    rect    = (hp_m > {3'b0, LP_MAX}) ? LP_MAX : hp_m[LP_W-1:0];
    lp_diff = {1'b0, rect} - {1'b0, lp_env_q};
    lp_dmag = lp_diff[LP_W] ? LP_W'(-lp_diff) : lp_diff[LP_W-1:0];

    lp_m    = rnd15[40:15];
    lp_t    = neg_q ? ({2'b0, lp_env_q} - {1'b0, lp_m}) : ({2'b0, lp_env_q} + {1'b0, lp_m});
    if (lp_t[26]) begin
      lp_new = '0;
    end else if (lp_t[25]) begin
      lp_new = LP_MAX;
    end else begin
      lp_new = lp_t[LP_W-1:0];
    end

    p_sum   = {1'b0, kf_var_q} + {1'b0, pns_q};
    p_new   = p_sum[VAR_W] ? '1 : p_sum[VAR_W-1:0];
    den     = {1'b0, p_new} + {1'b0, meas_q};

    kf_diff = {1'b0, lp_env_q} - {2'b0, kf_env_q};
    kf_dmag = kf_diff[LP_W] ? LP_W'(-kf_diff) : kf_diff[LP_W-1:0];
    kf_m    = rnd16[41:16];
    kf_t    = neg_q ? ({4'b0, kf_env_q} - {2'b0, kf_m}) : ({4'b0, kf_env_q} + {2'b0, kf_m});
    if (kf_t[27]) begin
      env_new = '0;
    end else if (kf_t[26:24] != 3'b0) begin
      env_new = ENV_MAX;
    end else begin
      env_new = kf_t[ENV_W-1:0];
    end

    mvc_eff = (mvc_q == '0) ? MVC_W'(1) : mvc_q;

    if (!flag_q && norm_q >= on_q) begin
      flag_n = 1'b1;
    end else if (flag_q && norm_q <= off_q) begin
      flag_n = 1'b0;
    end else begin
      flag_n = flag_q;
    end
  end

  // ---- divider requests ---------------------------------------------------
  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_LPR: begin
        div_req.start = (den != '0);
        div_req.num   = p_new;
        div_req.den   = den;
      end
      S_VARR: begin
        div_req.start = ({1'b0, kf_env_q} < {mvc_eff, 1'b0});
        div_req.num   = {8'b0, kf_env_q};
        div_req.den   = {9'b0, mvc_eff};
      end
      S_NPOST: begin
        div_req.start = (norm_q > {1'b0, dz_q});
        div_req.num   = {15'b0, 17'(norm_q - {1'b0, dz_q})};
        div_req.den   = {16'b0, 17'(LEVEL_ONE - {1'b0, dz_q})};
      end
      default: div_req = '0;
    endcase
  end

  assign in_ch.ready = (state_q == S_IDLE);

  // ---- configuration ------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hp_coef_q <= 16'd32768;
      lp_coef_q <= 16'd32768;
      pns_q     <= '0;
      meas_q    <= 32'd65536;
      mvc_q     <= 24'd256;
      dz_q      <= '0;
      on_q      <= 17'd39322;
      off_q     <= 17'd26214;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_HP_COEF:  hp_coef_q <= cfg_data_i[COEF_W-1:0];
        CFG_LP_COEF:  lp_coef_q <= cfg_data_i[COEF_W-1:0];
        CFG_PNS:      pns_q     <= cfg_data_i;
        CFG_MEAS:     meas_q    <= cfg_data_i;
        CFG_MVC:      mvc_q     <= cfg_data_i[MVC_W-1:0];
        CFG_DEADZONE: dz_q      <= cfg_data_i[DZ_W-1:0];
        CFG_ON:       on_q      <= cfg_data_i[LEVEL_W-1:0];
        CFG_OFF:      off_q     <= cfg_data_i[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- shared multiplier, registered --------------------------------------
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a_q * mul_b_q;
  end

  // ---- sequencer ----------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      hp_last_in_q  <= '0;
      hp_last_out_q <= '0;
      lp_env_q      <= '0;
      kf_env_q      <= '0;
      kf_var_q      <= 32'd65536;
      flag_q        <= 1'b0;
      primed_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      // drop the result once the sink takes it, unless a new one replaces it
      if (out_valid_q && out_ch.ready && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            hp_last_in_q <= in_ch.raw_sample;
            primed_q     <= 1'b1;
            mul_a_q      <= {5'b0, hp_mag};
            mul_b_q      <= {1'b0, hpc_lim};
            neg_q        <= hp_sum[26];
            state_q      <= S_HP;
          end
        end
        S_HP: state_q <= S_HPR;
        S_HPR: begin
          hp_last_out_q <= hp_sat;
          mul_a_q       <= {7'b0, lp_dmag};
          mul_b_q       <= {1'b0, lpc_lim};
          neg_q         <= lp_diff[LP_W];
          state_q       <= S_LP;
        end
        S_LP: state_q <= S_LPR;
        S_LPR: begin
          lp_env_q <= lp_new;
          p_q      <= p_new;
          // zero total variance: zero gain, estimate kept
          if (den == '0) begin
            k_q     <= '0;
            state_q <= S_KFM;
          end else begin
            state_q <= S_KDIV;
          end
        end
        S_KDIV: begin
          if (div_rsp.done) begin
            k_q     <= div_rsp.quot;
            state_q <= S_KFM;
          end
        end
        S_KFM: begin
          mul_a_q <= {7'b0, kf_dmag};
          mul_b_q <= k_q;
          neg_q   <= kf_diff[LP_W];
          state_q <= S_KF;
        end
        S_KF: state_q <= S_KFR;
        S_KFR: begin
          kf_env_q  <= env_new;
          mul_a_q   <= p_q;
          mul_b_q   <= LEVEL_ONE - k_q;
          state_q   <= S_VAR;
        end
        S_VAR: state_q <= S_VARR;
        S_VARR: begin
          kf_var_q <= rnd16[47:16];
          // envelope at twice MVC or more: clamp without dividing
          if ({1'b0, kf_env_q} >= {mvc_eff, 1'b0}) begin
            norm_q  <= LEVEL_ONE;
            state_q <= S_NPOST;
          end else begin
            state_q <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (div_rsp.done) begin
            norm_q  <= (div_rsp.quot > LEVEL_ONE) ? LEVEL_ONE : div_rsp.quot;
            state_q <= S_NPOST;
          end
        end
        S_NPOST: begin
          if (norm_q <= {1'b0, dz_q}) begin
            prop_q  <= '0;
            state_q <= S_FIN;
          end else begin
            state_q <= S_PDIV;
          end
        end
        S_PDIV: begin
          if (div_rsp.done) begin
            prop_q  <= (div_rsp.quot > LEVEL_ONE) ? LEVEL_ONE : div_rsp.quot;
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          // hold until the output register is free
          if (!out_valid_q || out_ch.ready) begin
            flag_q      <= flag_n;
            out_env_q   <= kf_env_q;
            out_norm_q  <= norm_q;
            out_prop_q  <= prop_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_valid_q;
  assign out_ch.envelope     = out_env_q;
  assign out_ch.normalized   = out_norm_q;
  assign out_ch.proportional = out_prop_q;
  assign out_ch.contracted   = flag_q;

endmodule
`default_nettype wire

// ===== dv/tb_emg_envelope_chain.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_emg_envelope_chain: self-checking testbench of the EMG envelope chain
// Drives raw samples over the valid/ready input channel with random gaps,
// stalls the result channel at random, and checks every result item field
// by field against a cycle-free predictor of the filter chain. Registers are
// rewritten between phases while the block is drained.
// ----------------------------------------------------------------------------
module tb_emg_envelope_chain;
  import emg_pkg::*;

  // One predicted result item
  typedef struct packed {
    logic [ENV_W-1:0]   envelope;
    logic [LEVEL_W-1:0] normalized;
    logic [LEVEL_W-1:0] proportional;
    logic               contracted;
  } env_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                 cfg_we  = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  emg_in_if  in_ch ();
  emg_out_if out_ch ();

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.raw_sample = '0;
    out_ch.ready     = 1'b0;
  end

  emg_envelope_chain u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  // Expected result items, oldest first
  env_result_t pending_results[$];
  int unsigned mismatch_cnt = 0;
  bit          idle_en = 1'b1;

  // Predictor copy of the registers
  longint unsigned m_hp_coef, m_lp_coef, m_pns, m_meas, m_mvc, m_dz, m_on, m_off;
  // Predictor copy of the filter state
  longint          m_hp_in, m_hp_out, m_lp_env, m_kf_env;
  longint unsigned m_kf_var;
  bit              m_flag, m_primed;

  function automatic void model_reset();
    m_hp_coef = 32768; m_lp_coef = 32768; m_pns = 0; m_meas = 65536;
    m_mvc = 256; m_dz = 0; m_on = 39322; m_off = 26214;
    m_hp_in = 0; m_hp_out = 0; m_lp_env = 0; m_kf_env = 0;
    m_kf_var = 65536; m_flag = 1'b0; m_primed = 1'b0;
  endfunction

  // Rounded product (v * c) >> sh, halves away from zero
  function automatic longint round_mul(longint v, longint unsigned c, int sh);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    mag = (mag * c + (64'd1 << (sh - 1))) >> sh;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  function automatic longint unsigned coef_sat(longint unsigned c);
    return (c > 32768) ? 64'd32768 : c;
  endfunction

  // Advance the predicted chain by one sample and return the result item
  function automatic env_result_t chain_step(logic signed [SAMPLE_W-1:0] raw);
    longint x, sum, hp, rect, lp_max, env;
    longint unsigned p, den, k, mvc, norm, prop;
    env_result_t r;
    x = raw;
    if (!m_primed) begin
      m_hp_in = x; m_hp_out = 0; m_primed = 1'b1;
    end
    sum = m_hp_out + (x - m_hp_in) * 256;
    hp = clip(round_mul(sum, coef_sat(m_hp_coef), 15), -(64'sd1 << 25), (64'sd1 << 25) - 1);
    m_hp_in = x;
    m_hp_out = hp;
    lp_max = (64'sd1 << LP_W) - 1;
    rect = clip((hp < 0) ? -hp : hp, 0, lp_max);
    m_lp_env = clip(m_lp_env + round_mul(rect - m_lp_env, coef_sat(m_lp_coef), 15),
                    0, lp_max);
    p = m_kf_var + m_pns;
    if (p > 64'hFFFF_FFFF) p = 64'hFFFF_FFFF;
    den = p + m_meas;
    k = (den != 0) ? (p << 16) / den : 0;
    env = clip(m_kf_env + round_mul(m_lp_env - m_kf_env, k, 16), 0, 64'hFF_FFFF);
    m_kf_env = env;
    m_kf_var = ((65536 - k) * p + 32768) >> 16;
    mvc = (m_mvc != 0) ? m_mvc : 1;
    norm = (longint'(env) << 16) / mvc;
    if (norm > 65536) norm = 65536;
    if (norm <= m_dz) begin
      prop = 0;
    end else begin
      prop = ((norm - m_dz) << 16) / (65536 - m_dz);
      if (prop > 65536) prop = 65536;
    end
    if (!m_flag && norm >= m_on) m_flag = 1'b1;
    else if (m_flag && norm <= m_off) m_flag = 1'b0;
    r.envelope = env[ENV_W-1:0];
    r.normalized = norm[LEVEL_W-1:0];
    r.proportional = prop[LEVEL_W-1:0];
    r.contracted = m_flag;
    return r;
  endfunction

  // Result channel: random stall bursts
  int unsigned stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 18);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each accepted result item with the oldest expectation
  always @(posedge clk_i) begin
    env_result_t want, got;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.envelope, out_ch.normalized, out_ch.proportional, out_ch.contracted};
      if (pending_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch: env exp %0d got %0d, norm exp %0d got %0d, prop exp %0d got %0d, con exp %0d got %0d",
                     want.envelope, got.envelope, want.normalized, got.normalized,
                     want.proportional, got.proportional, want.contracted, got.contracted);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 4000) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Offer one sample, hold until accepted, then maybe insert a gap
  task automatic send_sample(logic [SAMPLE_W-1:0] raw);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.raw_sample <= raw;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(chain_step(raw));
    if (idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected item has arrived
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HP_COEF:  m_hp_coef = value[15:0];
      CFG_LP_COEF:  m_lp_coef = value[15:0];
      CFG_PNS:      m_pns = value;
      CFG_MEAS:     m_meas = value;
      CFG_MVC:      m_mvc = value[23:0];
      CFG_DEADZONE: m_dz = value[15:0];
      CFG_ON:       m_on = value[16:0];
      CFG_OFF:      m_off = value[16:0];
      default: ;
    endcase
  endtask

  // Defaults after reset: priming, full-scale steps, both signs
  task automatic test_defaults();
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h0001);
  endtask

  // Coefficients above one act as one; a zero high-pass coefficient zeroes its output, a zero low-pass one freezes it
  task automatic test_coef_extremes();
    write_reg(CFG_HP_COEF, 32'h0000_FFFF);
    write_reg(CFG_LP_COEF, 32'h0000_9000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    write_reg(CFG_HP_COEF, 32'd0);
    write_reg(CFG_LP_COEF, 32'd0);
    send_sample(16'h1234);
    send_sample(16'h8000);
  endtask

  // Saturating variance, zero total variance, zero MVC, odd thresholds
  task automatic test_kalman_levels();
    write_reg(CFG_HP_COEF, 32'd32768);
    write_reg(CFG_LP_COEF, 32'd32768);
    write_reg(CFG_PNS, 32'hFFFF_FFFF);
    write_reg(CFG_MEAS, 32'hFFFF_FFFF);
    send_sample(16'h7FFF);
    send_sample(16'h8000);
    write_reg(CFG_PNS, 32'd0);
    write_reg(CFG_MEAS, 32'd0);
    send_sample(16'h4000);
    send_sample(16'hC000);
    send_sample(16'h7FFF);
    write_reg(CFG_MEAS, 32'd65536);
    write_reg(CFG_MVC, 32'd0);
    write_reg(CFG_DEADZONE, 32'hFFFF);
    write_reg(CFG_ON, 32'h1_FFFF);
    write_reg(CFG_OFF, 32'h1_FFFF);
    send_sample(16'h8000);
    send_sample(16'h7FFF);
    write_reg(CFG_ON, 32'd0);
    send_sample(16'h0000);
  endtask

  // Random register settings with bursts of activity and quiet stretches
  task automatic test_random(int unsigned phases, int unsigned per_phase);
    int unsigned sent, len, amp;
    logic [CFG_W-1:0] v;
    for (int ph = 0; ph < phases; ph++) begin
      if (ph == phases - 1) idle_en = 1'b0;
      v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(28000, 32768);
      write_reg(CFG_HP_COEF, v);
      v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(200, 8000);
      write_reg(CFG_LP_COEF, v);
      write_reg(CFG_PNS, ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 200000));
      write_reg(CFG_MEAS, ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 400000));
      v = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(1, 1 << 21);
      write_reg(CFG_MVC, v);
      write_reg(CFG_DEADZONE, ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20000));
      v = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(20000, 65536);
      write_reg(CFG_ON, v);
      v = ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 40000);
      write_reg(CFG_OFF, v);
      sent = 0;
      while (sent < per_phase) begin
        // Contraction bursts of random strength, then rest
        len = $urandom_range(4, 30);
        case ($urandom_range(0, 3))
          0: amp = 100;
          1: amp = 3000;
          2: amp = 15000;
          default: amp = 32768;
        endcase
        for (int i = 0; i < len && sent < per_phase; i++) begin
          send_sample(16'($signed($urandom_range(0, 2 * amp)) - $signed(amp)));
          sent++;
        end
      end
    end
  endtask

  initial begin
    model_reset();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults();
    test_coef_extremes();
    test_kalman_levels();
    test_random(9, 72);
    drain();
    repeat (80) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
